// File: hdl/bcgd_pkg.sv
package bcgd_pkg;

  // Fixed widths of the configuration channel
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;

  // Timer default width and register reset values
  localparam int unsigned TIMER_WIDTH_DEF  = 20;
  localparam int unsigned DBL_TICKS_RESET  = 32768;
  localparam int unsigned LONG_TICKS_RESET = 16384;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DOUBLE_CLICK_TICKS = 2'd0,
    REG_LONG_CLICK_TICKS   = 2'd1
  } cfg_reg_t;

  // One result: the seven event flags of a tick
  typedef struct packed {
    logic click_begin;
    logic click_end;
    logic click;
    logic double_click;
    logic long_begin;
    logic long_end;
    logic long_click;
  } flags_t;

endpackage

// File: hdl/bcgd_cfg_regs.sv
module bcgd_cfg_regs #(
  parameter int unsigned TIMER_WIDTH = bcgd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [bcgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcgd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic [TIMER_WIDTH-1:0]           dbl_ticks,
  output logic [TIMER_WIDTH-1:0]           long_ticks
);
  import bcgd_pkg::*;

  logic [TIMER_WIDTH-1:0]            dbl_ticks_r;
  logic [TIMER_WIDTH-1:0]            long_ticks_r;
  logic [TIMER_WIDTH+CFG_DATA_W-1:0] wdata_ext;
  logic [TIMER_WIDTH-1:0]            wdata_fit;

  // Zero-extend, then keep the timer width (truncates when narrower)
  assign wdata_ext = {{TIMER_WIDTH{1'b0}}, cfg_wdata};
  assign wdata_fit = wdata_ext[TIMER_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_ticks_r  <= TIMER_WIDTH'(DBL_TICKS_RESET);
      long_ticks_r <= TIMER_WIDTH'(LONG_TICKS_RESET);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DOUBLE_CLICK_TICKS: dbl_ticks_r  <= wdata_fit;
        REG_LONG_CLICK_TICKS:   long_ticks_r <= wdata_fit;
        default: ;
      endcase
    end
  end

  assign dbl_ticks  = dbl_ticks_r;
  assign long_ticks = long_ticks_r;

endmodule

// File: hdl/bcgd_core.sv
module bcgd_core #(
  parameter int unsigned TIMER_WIDTH = bcgd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   level,
  input  logic [TIMER_WIDTH-1:0] dbl_ticks,
  input  logic [TIMER_WIDTH-1:0] long_ticks,
  output bcgd_pkg::flags_t       flags
);
  import bcgd_pkg::*;

  logic                   last_level_r,  last_level_nxt;
  logic                   pending_r,     pending_nxt;
  logic                   long_act_r,    long_act_nxt;
  logic [TIMER_WIDTH-1:0] dbl_cnt_r,     dbl_cnt_nxt;
  logic                   dbl_run_r,     dbl_run_nxt;
  logic [TIMER_WIDTH-1:0] long_cnt_r,    long_cnt_nxt;
  logic                   long_run_r,    long_run_nxt;

  logic long_exp;
  logic dbl_exp;

  // A running timer at one or zero expires this tick
  assign long_exp = long_run_r && (long_cnt_r <= TIMER_WIDTH'(1));
  assign dbl_exp  = dbl_run_r  && (dbl_cnt_r  <= TIMER_WIDTH'(1));

  always_comb begin
    last_level_nxt = last_level_r;
    pending_nxt    = pending_r;
    long_act_nxt   = long_act_r;
    dbl_cnt_nxt    = dbl_cnt_r;
    dbl_run_nxt    = dbl_run_r;
    long_cnt_nxt   = long_cnt_r;
    long_run_nxt   = long_run_r;
    flags          = '0;

    // Long timer first
    if (long_run_r) begin
      if (long_exp) begin
        long_cnt_nxt      = '0;
        long_run_nxt      = 1'b0;
        long_act_nxt      = level;
        flags.long_begin  = level;
      end else begin
        long_cnt_nxt = long_cnt_r - TIMER_WIDTH'(1);
      end
    end

    // Double-click window; its expiry starts the long timer
    if (dbl_run_r) begin
      if (dbl_exp) begin
        dbl_cnt_nxt  = '0;
        dbl_run_nxt  = 1'b0;
        pending_nxt  = 1'b0;
        long_act_nxt = 1'b0;
        long_cnt_nxt = long_ticks;
        long_run_nxt = 1'b1;
      end else begin
        dbl_cnt_nxt = dbl_cnt_r - TIMER_WIDTH'(1);
      end
    end

    // Level change
    if (level != last_level_r) begin
      long_run_nxt = 1'b0;
      long_cnt_nxt = '0;
      if (long_act_nxt) begin
        flags.long_end   = 1'b1;
        flags.long_click = 1'b1;
        long_act_nxt     = 1'b0;
      end
      if (level) begin
        dbl_run_nxt       = 1'b0;
        dbl_cnt_nxt       = '0;
        flags.click_begin = 1'b1;
        if (pending_nxt) begin
          pending_nxt        = 1'b0;
          flags.double_click = 1'b1;
        end else begin
          pending_nxt = 1'b1;
          dbl_cnt_nxt = dbl_ticks;
          dbl_run_nxt = 1'b1;
        end
      end else begin
        flags.click_end = 1'b1;
        flags.click     = 1'b1;
      end
      last_level_nxt = level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= 1'b0;
      pending_r    <= 1'b0;
      long_act_r   <= 1'b0;
      dbl_cnt_r    <= '0;
      dbl_run_r    <= 1'b0;
      long_cnt_r   <= '0;
      long_run_r   <= 1'b0;
    end else if (adv) begin
      last_level_r <= last_level_nxt;
      pending_r    <= pending_nxt;
      long_act_r   <= long_act_nxt;
      dbl_cnt_r    <= dbl_cnt_nxt;
      dbl_run_r    <= dbl_run_nxt;
      long_cnt_r   <= long_cnt_nxt;
      long_run_r   <= long_run_nxt;
    end
  end

endmodule

// File: hdl/button_click_gesture_detector_top.sv
// Button click gesture detector.
// Input channel (in_valid / in_stall / in_pressed): one transaction per timer
// tick, carrying the sampled button level. Result channel (out_valid /
// out_stall / out_*): exactly one transaction per input tick, seven event
// flags (click begin/end, click, double click, long begin/end/click).
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_wdata):
// index 0 sets the double-click window, index 1 the long-click delay, both in
// ticks; other indexes are ignored. cfg_ready is always high. Write only while
// the block is idle; a new value applies at the next timer start.
// A tick is held in the input register, then its flags in the result
// register. Throughput: one tick per cycle while the receiver does not stall;
// the whole tick update is one pass of logic between the two registers.
// Reset (rst_n low, synchronous): both channels go empty, the button level,
// pending-click and long-click state and both timers clear, and the two
// configuration registers return to 32768 and 16384 ticks.
// Receiver stall: the result register holds; the input register keeps its
// tick and in_stall rises, so no tick is lost or processed twice.
module button_click_gesture_detector_top #(
  parameter int unsigned TIMER_WIDTH = bcgd_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_pressed,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_click_begin,
  output logic                             out_click_end,
  output logic                             out_click,
  output logic                             out_double_click,
  output logic                             out_long_begin,
  output logic                             out_long_end,
  output logic                             out_long_click,
  // Configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bcgd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bcgd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bcgd_pkg::*;

  logic                   in_valid_r,  in_valid_nxt;
  logic                   in_level_r;
  logic                   out_valid_r, out_valid_nxt;
  flags_t                 out_flags_r;
  flags_t                 flags;
  logic                   in_accept;
  logic                   adv;
  logic [TIMER_WIDTH-1:0] dbl_ticks;
  logic [TIMER_WIDTH-1:0] long_ticks;

  assign cfg_ready = 1'b1;

  // Process the held tick whenever the result register is free or draining
  assign adv       = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !adv;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: capture the tick on accept, the flags on advance
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_level_r <= in_pressed;
    end
    if (adv) begin
      out_flags_r <= flags;
    end
  end

  bcgd_cfg_regs #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_cfg_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .dbl_ticks  (dbl_ticks),
    .long_ticks (long_ticks)
  );

  bcgd_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .level      (in_level_r),
    .dbl_ticks  (dbl_ticks),
    .long_ticks (long_ticks),
    .flags      (flags)
  );

  assign out_valid        = out_valid_r;
  assign out_click_begin  = out_flags_r.click_begin;
  assign out_click_end    = out_flags_r.click_end;
  assign out_click        = out_flags_r.click;
  assign out_double_click = out_flags_r.double_click;
  assign out_long_begin   = out_flags_r.long_begin;
  assign out_long_end     = out_flags_r.long_end;
  assign out_long_click   = out_flags_r.long_click;

endmodule

// File: bench/tb_button_click_gesture_detector_top.sv
module tb_button_click_gesture_detector_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcgd_pkg::*;

  // Indexes past the register list; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 2'd3;
  localparam logic [CFG_DATA_W-1:0] TICKS_MAX = '1;

  // Tracks the gesture state of the block, one tick at a time, and holds the
  // flag sets still owed by the result channel.
  class gesture_scoreboard;
    logic [CFG_DATA_W-1:0] dbl_ticks;
    logic [CFG_DATA_W-1:0] long_ticks;
    logic                  level;
    logic                  single_open;
    logic                  long_held;
    logic [CFG_DATA_W-1:0] dbl_cnt;
    logic                  dbl_run;
    logic [CFG_DATA_W-1:0] long_cnt;
    logic                  long_run;
    flags_t                owed_flags[$];
    int unsigned           mismatches;
    int unsigned           n_double;
    int unsigned           n_long_begin;
    int unsigned           n_long_end;

    function new();
      dbl_ticks    = CFG_DATA_W'(DBL_TICKS_RESET);
      long_ticks   = CFG_DATA_W'(LONG_TICKS_RESET);
      level        = 1'b0;
      single_open  = 1'b0;
      long_held    = 1'b0;
      dbl_cnt      = '0;
      dbl_run      = 1'b0;
      long_cnt     = '0;
      long_run     = 1'b0;
      mismatches   = 0;
      n_double     = 0;
      n_long_begin = 0;
      n_long_end   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_DOUBLE_CLICK_TICKS) dbl_ticks = val;
      else if (idx == REG_LONG_CLICK_TICKS) long_ticks = val;
    endfunction

    // Count down a running timer; report expiry when it runs out (0 acts as 1).
    function bit count_down(inout logic [CFG_DATA_W-1:0] cnt, inout logic run);
      if (!run) return 1'b0;
      if (cnt <= 1) begin
        cnt = '0;
        run = 1'b0;
        return 1'b1;
      end
      cnt = cnt - 1'b1;
      return 1'b0;
    endfunction

    function void note_tick(logic lvl);
      flags_t f;
      f = '0;
      // Long timer first, then the double-click window, then the edge.
      if (count_down(long_cnt, long_run)) begin
        long_held    = lvl;
        f.long_begin = lvl;
      end
      if (count_down(dbl_cnt, dbl_run)) begin
        single_open = 1'b0;
        long_held   = 1'b0;
        long_cnt    = long_ticks;
        long_run    = 1'b1;
      end
      if (lvl != level) begin
        long_run = 1'b0;
        long_cnt = '0;
        if (long_held) begin
          f.long_end   = 1'b1;
          f.long_click = 1'b1;
          long_held    = 1'b0;
        end
        if (lvl) begin
          dbl_run       = 1'b0;
          dbl_cnt       = '0;
          f.click_begin = 1'b1;
          if (single_open) begin
            single_open    = 1'b0;
            f.double_click = 1'b1;
          end else begin
            single_open = 1'b1;
            dbl_cnt     = dbl_ticks;
            dbl_run     = 1'b1;
          end
        end else begin
          f.click_end = 1'b1;
          f.click     = 1'b1;
        end
        level = lvl;
      end
      n_double     += f.double_click;
      n_long_begin += f.long_begin;
      n_long_end   += f.long_end;
      owed_flags.push_back(f);
    endfunction

    function void check_flag(string name, logic exp_v, logic act_v);
      if (act_v !== exp_v) begin
        mismatches++;
        $display("%0t: %s mismatch: expected %b, actual %b", $realtime, name, exp_v, act_v);
      end
    endfunction

    function void check_flags(flags_t act);
      flags_t exp_f;
      if (owed_flags.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tick waiting: expected none, actual %b",
                 $realtime, act);
        return;
      end
      exp_f = owed_flags.pop_front();
      check_flag("click_begin",  exp_f.click_begin,  act.click_begin);
      check_flag("click_end",    exp_f.click_end,    act.click_end);
      check_flag("click",        exp_f.click,        act.click);
      check_flag("double_click", exp_f.double_click, act.double_click);
      check_flag("long_begin",   exp_f.long_begin,   act.long_begin);
      check_flag("long_end",     exp_f.long_end,     act.long_end);
      check_flag("long_click",   exp_f.long_click,   act.long_click);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_pressed = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_click_begin;
  logic                  out_click_end;
  logic                  out_click;
  logic                  out_double_click;
  logic                  out_long_begin;
  logic                  out_long_end;
  logic                  out_long_click;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gesture_scoreboard board = new();
  bit                calm = 1'b0;  // suppress idling and stalls on both sides
  int unsigned       ticks_sent = 0;
  int unsigned       settings_used = 0;

  button_click_gesture_detector_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pressed       (in_pressed),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_click_begin  (out_click_begin),
    .out_click_end    (out_click_end),
    .out_click        (out_click),
    .out_double_click (out_double_click),
    .out_long_begin   (out_long_begin),
    .out_long_end     (out_long_end),
    .out_long_click   (out_long_click),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall at random about 14 percent of the time, never while calm.
  always @(posedge clk) begin
    out_stall <= !calm && rst_n && ($urandom_range(0, 99) < 14);
  end

  // Check every result transaction against the oldest owed flag set. Values
  // read here are the ones the block saw at this edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_flags({out_click_begin, out_click_end, out_click, out_double_click,
                         out_long_begin, out_long_end, out_long_click});
    end
  end

  // Send one tick; now and then drop valid for a short random gap first.
  task automatic send_tick(input logic lvl);
    int gap;
    if (!calm && $urandom_range(0, 99) < 14) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= lvl;
    do @(posedge clk); while (in_stall);
    board.note_tick(lvl);
    ticks_sent++;
  endtask

  task automatic hold_level(input logic lvl, input int n);
    repeat (n) send_tick(lvl);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.owed_flags.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register transaction; valid stays high for back-to-back writes.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, val);
  endtask

  // Write both timer registers plus a junk write to a spare index. Call only
  // with the block drained.
  task automatic program_timers(input logic [CFG_DATA_W-1:0] dbl,
                                input logic [CFG_DATA_W-1:0] lng,
                                input logic [CFG_IDX_W-1:0] spare);
    cfg_write(REG_DOUBLE_CLICK_TICKS, dbl);
    cfg_write(REG_LONG_CLICK_TICKS, lng);
    cfg_write(spare, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Mostly whole press/release gestures with durations that straddle the
  // double-click and long-click thresholds; the rest is level noise.
  task automatic run_gestures(input int n_items);
    int stop_at;
    int horizon;
    int k;
    stop_at = ticks_sent + n_items;
    horizon = board.dbl_ticks + board.long_ticks + 2;
    if (horizon > 24 || horizon < 0) horizon = 24;
    if (horizon < 3) horizon = 3;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        hold_level(1'b1, $urandom_range(1, horizon));
        hold_level(1'b0, $urandom_range(1, horizon));
      end else begin
        k = $urandom_range(1, 6);
        repeat (k) send_tick(1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset timer values: single click, then a second press within the window.
    hold_level(1'b1, 1);
    hold_level(1'b0, 1);
    hold_level(1'b1, 1);
    hold_level(1'b0, 2);
    drain();

    // Short windows: hold through to a long click and release it, then a
    // lone click whose long timer runs out with the button up.
    program_timers(20'd2, 20'd2, IDX_SPARE_LO);
    hold_level(1'b1, 6);
    hold_level(1'b0, 1);
    hold_level(1'b1, 1);
    hold_level(1'b0, 6);
    drain();

    program_timers(20'd2, 20'd3, IDX_SPARE_HI);
    run_gestures(150);
    drain();

    program_timers(20'd1, 20'd1, IDX_SPARE_LO);
    run_gestures(100);
    drain();

    // Zero registers behave as a one-tick timer.
    program_timers(20'd0, 20'd0, IDX_SPARE_HI);
    run_gestures(50);
    drain();

    // Long stretch with no idling on either side.
    calm = 1'b1;
    program_timers(20'd5, 20'd2, IDX_SPARE_LO);
    run_gestures(120);
    drain();
    calm = 1'b0;

    program_timers(20'd3, 20'd7, IDX_SPARE_HI);
    run_gestures(80);
    drain();

    // Largest values: the long timer (or the window) never runs out here.
    program_timers(20'd1, TICKS_MAX, IDX_SPARE_LO);
    run_gestures(30);
    drain();
    program_timers(TICKS_MAX, TICKS_MAX, IDX_SPARE_HI);
    run_gestures(20);
    drain();

    program_timers(CFG_DATA_W'($urandom_range(1, 6)), CFG_DATA_W'($urandom_range(1, 6)),
                   IDX_SPARE_LO);
    run_gestures(60);
    drain();

    $display("Covered %0d ticks over %0d timer settings plus the reset values.",
             ticks_sent, settings_used);
    $display("Predicted %0d double clicks, %0d long presses, %0d long releases.",
             board.n_double, board.n_long_begin, board.n_long_end);
    if (board.mismatches == 0 && board.owed_flags.size() == 0) begin
      $display("** button_click_gesture_detector_top: PASSED **");
    end else begin
      $display("** button_click_gesture_detector_top: FAILED **");
    end
    $finish;
  end

  // Give up on a hang.
  initial begin
    #2_000_000;
    $display("Timeout with %0d results outstanding", board.owed_flags.size());
    $display("** button_click_gesture_detector_top: FAILED **");
    $finish;
  end

endmodule
